### hdl/rcast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raycaster package
// Shared types, constants and codes for the DDA grid wall raycaster.
// ----------------------------------------------------------------------------
package rcast_pkg;

  // Map and texture geometry
  localparam int MAP_SIZE  = 64;
  localparam int TEX_WIDTH = 64;
  localparam int MAP_BITS  = $clog2(MAP_SIZE);
  localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  // cell coordinates: one spare bit for leaving the grid, wide enough for pos >> 8
  localparam int CRD_W     = (MAP_BITS + 1 > 7) ? MAP_BITS + 1 : 7;
  localparam int MAX_STEPS = 2 * MAP_SIZE + 2;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  // Arithmetic widths
  localparam int DIV_W  = 32;  // shared divider width
  localparam int SUM_W  = 42;  // Q26.16 walk distance sums
  localparam int RAY_W  = 30;  // Q2.14 ray component, kept wide
  localparam int CAM_W  = 27;  // camera x, signed Q2.14
  localparam int CFG_W  = 16;  // widest config register
  localparam int CIDX_W = 3;

  localparam logic [DIV_W-1:0] DIV_ONE   = 32'h4000_0000;  // 2^30
  localparam logic [DIV_W-1:0] DELTA_MAX = 32'hFFFF_FFFF;

  // Item action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_CAM_POS_X   = 3'd0,
    REG_CAM_POS_Y   = 3'd1,
    REG_VIEW_DIR_X  = 3'd2,
    REG_VIEW_DIR_Y  = 3'd3,
    REG_CAM_PLANE_X = 3'd4,
    REG_CAM_PLANE_Y = 3'd5,
    REG_SCR_WIDTH   = 3'd6,
    REG_SCR_HEIGHT  = 3'd7
  } cfg_reg_e;

  // Divider operand select
  typedef enum logic [1:0] {
    DIV_CAM,
    DIV_DX,
    DIV_DY,
    DIV_HGT
  } div_sel_e;

  typedef struct packed {
    logic        action;
    logic [9:0]  column;
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic [7:0]  cell_code;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic [15:0] perp_distance;
    logic        hit_side;
    logic [7:0]  wall_code;
    logic [15:0] column_height;
    logic [10:0] draw_top;
    logic [10:0] draw_bottom;
    logic [5:0]  texture_column;
    logic        escaped;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic     clear;
    logic     wr_cell;
    logic     ld_item;
    logic     div_start;
    div_sel_e div_sel;
    logic     ld_cam;
    logic     mul_ray;
    logic     add_ray;
    logic     ld_dx;
    logic     ld_dy;
    logic     init_walk;
    logic     walk_step;
    logic     ld_pd;
    logic     ld_frac;
    logic     ld_lh;
    logic     emit_hit;
    logic     emit_esc;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic oob;
    logic hit;
    logic walk_limit;
  } dp_sts_t;

endpackage

### hdl/rcast_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raycaster divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcast_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rcast_pkg::DIV_W-1:0] num_i,
  input  logic [rcast_pkg::DIV_W-1:0] den_i,
  output logic                      done_o,
  output logic [rcast_pkg::DIV_W-1:0] quot_o
);
  import rcast_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             run_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] num_q, den_q, rem_q;
  logic [DIV_W:0]   rem_sh, rem_d;
  logic             ge;

  // one restoring step; quotient bits shift into num_q
  always_comb begin
    rem_sh = {rem_q, num_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DIV_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands; the remainder stays below the divisor, so 32 bits hold it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[DIV_W-2:0], ge};
      rem_q <= rem_d[DIV_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

### hdl/rcast_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raycaster datapath
// Config registers, tile map, ray setup, DDA walk and result formatting.
// ----------------------------------------------------------------------------
module rcast_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcast_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [rcast_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  rcast_pkg::in_item_t           item_i,
  input  rcast_pkg::dp_cmd_t            cmd_i,
  output rcast_pkg::dp_sts_t            sts_o,
  output logic                          res_valid_o,
  output rcast_pkg::out_item_t          res_o
);
  import rcast_pkg::*;

  // configuration
  logic [13:0]        pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, pl_x_q, pl_y_q;
  logic [10:0]        scr_w_q, scr_h_q;

  // per-item state
  logic [9:0]               col_q;
  logic signed [CAM_W-1:0]  cam_q, cam_d;
  logic signed [CAM_W+15:0] prod_x_q, prod_y_q;
  logic signed [RAY_W-1:0]  rx_q, ry_q;
  logic [RAY_W-1:0]         mag_x, mag_y;
  logic [DIV_W-1:0]         dx_q, dy_q;
  logic [SUM_W-1:0]         sx_q, sy_q;
  logic [CRD_W-1:0]         mx_q, my_q, mx_n, my_n;
  logic                     side_q, take_x;
  logic [STEP_W-1:0]        steps_q;
  logic [7:0]               rd_q;
  logic [15:0]              pd_q, lh_q;
  logic [21:0]              frac_q;
  logic [ADDR_W-1:0]        clr_cnt_q, rd_addr;

  // tile map
  logic [7:0] mem_q [MAP_DEPTH];
  logic       mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0] mem_wdata;

  // divider
  logic [DIV_W-1:0] div_num, div_den, quot;
  logic             div_done;
  logic [10:0]      w_eff;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      dir_x_q <= 16'sd16384;
      dir_y_q <= '0;
      pl_x_q  <= '0;
      pl_y_q  <= 16'sd10813;
      scr_w_q <= 11'd640;
      scr_h_q <= 11'd480;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CAM_POS_X:   pos_x_q <= cfg_wdata_i[13:0];
        REG_CAM_POS_Y:   pos_y_q <= cfg_wdata_i[13:0];
        REG_VIEW_DIR_X:  dir_x_q <= cfg_wdata_i;
        REG_VIEW_DIR_Y:  dir_y_q <= cfg_wdata_i;
        REG_CAM_PLANE_X: pl_x_q  <= cfg_wdata_i;
        REG_CAM_PLANE_Y: pl_y_q  <= cfg_wdata_i;
        REG_SCR_WIDTH:   scr_w_q <= cfg_wdata_i[10:0];
        REG_SCR_HEIGHT:  scr_h_q <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // divider operands
  assign w_eff = (scr_w_q == '0) ? 11'd1 : scr_w_q;
  assign mag_x = rx_q[RAY_W-1] ? RAY_W'(-rx_q) : RAY_W'(rx_q);
  assign mag_y = ry_q[RAY_W-1] ? RAY_W'(-ry_q) : RAY_W'(ry_q);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_CAM: begin
        div_num = {7'b0, col_q, 15'b0};
        div_den = DIV_W'(w_eff);
      end
      DIV_DX: begin
        div_num = DIV_ONE;
        div_den = DIV_W'(mag_x);
      end
      DIV_DY: begin
        div_num = DIV_ONE;
        div_den = DIV_W'(mag_y);
      end
      DIV_HGT: begin
        div_num = {13'b0, scr_h_q, 8'b0};
        div_den = DIV_W'(pd_q);
      end
      default: begin
        div_num = {7'b0, col_q, 15'b0};
        div_den = DIV_W'(w_eff);
      end
    endcase
  end

  rcast_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // camera x: quotient fits 25 bits
  assign cam_d = $signed({2'b00, quot[24:0]}) - CAM_W'(16384);

  // DDA next cell
  always_comb begin
    take_x = sx_q < sy_q;
    mx_n   = mx_q;
    my_n   = my_q;
    if (take_x) begin
      mx_n = rx_q[RAY_W-1] ? mx_q - 1'b1 : mx_q + 1'b1;
    end else begin
      my_n = ry_q[RAY_W-1] ? my_q - 1'b1 : my_q + 1'b1;
    end
    rd_addr = ADDR_W'(my_n[MAP_BITS-1:0]) * ADDR_W'(MAP_SIZE)
            + ADDR_W'(mx_n[MAP_BITS-1:0]);
  end

  // side starts
  logic [8:0]  fx, fy;
  logic [40:0] spx, spy;
  always_comb begin
    fx  = rx_q[RAY_W-1] ? {1'b0, pos_x_q[7:0]} : 9'd256 - {1'b0, pos_x_q[7:0]};
    fy  = ry_q[RAY_W-1] ? {1'b0, pos_y_q[7:0]} : 9'd256 - {1'b0, pos_y_q[7:0]};
    spx = 41'(fx) * 41'(dx_q);
    spy = 41'(fy) * 41'(dy_q);
  end

  // perpendicular distance
  logic [SUM_W-1:0] dsel;
  logic [15:0]      pd_d;
  always_comb begin
    dsel = side_q ? sy_q - SUM_W'(dy_q) : sx_q - SUM_W'(dx_q);
    pd_d = (|dsel[SUM_W-1:24]) ? 16'hFFFF : dsel[23:8];
  end

  // wall hit fraction, low 22 bits only
  logic signed [RAY_W+16:0] fprod;
  logic [13:0]              fpos;
  always_comb begin
    fprod = $signed({1'b0, pd_q}) * (side_q ? rx_q : ry_q);
    fpos  = side_q ? pos_x_q : pos_y_q;
  end

  // per-item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) col_q <= item_i.column;
    if (cmd_i.ld_cam) cam_q <= cam_d;
    if (cmd_i.mul_ray) begin
      prod_x_q <= (CAM_W+16)'(pl_x_q) * (CAM_W+16)'(cam_q);
      prod_y_q <= (CAM_W+16)'(pl_y_q) * (CAM_W+16)'(cam_q);
    end
    if (cmd_i.add_ray) begin
      rx_q <= RAY_W'(dir_x_q) + RAY_W'(prod_x_q >>> 14);
      ry_q <= RAY_W'(dir_y_q) + RAY_W'(prod_y_q >>> 14);
    end
    if (cmd_i.ld_dx) dx_q <= (mag_x == '0) ? DELTA_MAX : quot;
    if (cmd_i.ld_dy) dy_q <= (mag_y == '0) ? DELTA_MAX : quot;
    if (cmd_i.init_walk) begin
      sx_q    <= SUM_W'(spx >> 8);
      sy_q    <= SUM_W'(spy >> 8);
      mx_q    <= CRD_W'(pos_x_q[13:8]);
      my_q    <= CRD_W'(pos_y_q[13:8]);
      side_q  <= 1'b0;
      steps_q <= '0;
    end else if (cmd_i.walk_step) begin
      if (take_x) sx_q <= sx_q + SUM_W'(dx_q);
      else        sy_q <= sy_q + SUM_W'(dy_q);
      mx_q    <= mx_n;
      my_q    <= my_n;
      side_q  <= ~take_x;
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.ld_pd) pd_q <= pd_d;
    if (cmd_i.ld_frac) frac_q <= {fpos[7:0], 14'b0} + fprod[21:0];
    if (cmd_i.ld_lh) begin
      lh_q <= (pd_q == '0 || |quot[DIV_W-1:16]) ? 16'hFFFF : quot[15:0];
    end
  end

  // clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // tile map write port: clear sweep or cell write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.wr_cell && (int'(item_i.cell_col) < MAP_SIZE)
                 && (int'(item_i.cell_row) < MAP_SIZE)) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(item_i.cell_row) * ADDR_W'(MAP_SIZE)
                + ADDR_W'(item_i.cell_col);
      mem_wdata = item_i.cell_code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.walk_step) rd_q <= mem_q[rd_addr];
  end

  // status
  assign sts_o.clear_last = (clr_cnt_q == ADDR_W'(MAP_DEPTH - 1));
  assign sts_o.div_done   = div_done;
  assign sts_o.oob        = (int'(mx_q) >= MAP_SIZE) || (int'(my_q) >= MAP_SIZE);
  assign sts_o.hit        = (rd_q != '0);
  assign sts_o.walk_limit = (steps_q == STEP_W'(MAX_STEPS));

  // draw span and texture column
  logic [10:0] hh, top;
  logic [16:0] bot17;
  logic [10:0] bot;
  logic [30:0] tex_prod;
  logic [8:0]  tex_raw, tex_m;
  logic        mirror;
  always_comb begin
    hh       = {1'b0, scr_h_q[10:1]};
    top      = (16'(hh) >= {1'b0, lh_q[15:1]}) ? 11'(16'(hh) - {1'b0, lh_q[15:1]}) : '0;
    bot17    = 17'(top) + 17'(lh_q);
    bot      = (bot17 > 17'(scr_h_q)) ? scr_h_q : bot17[10:0];
    tex_prod = 31'(frac_q) * 31'(TEX_WIDTH);
    tex_raw  = tex_prod[30:22];
    tex_m    = 9'(TEX_WIDTH - 1) - tex_raw;
    mirror   = (!side_q && !rx_q[RAY_W-1] && (rx_q != '0)) || (side_q && ry_q[RAY_W-1]);
  end

  // result register
  out_item_t res_q;
  logic      res_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_hit | cmd_i.emit_esc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_hit) begin
      res_q.column_out     <= col_q;
      res_q.perp_distance  <= pd_q;
      res_q.hit_side       <= side_q;
      res_q.wall_code      <= rd_q;
      res_q.column_height  <= lh_q;
      res_q.draw_top       <= top;
      res_q.draw_bottom    <= bot;
      res_q.texture_column <= 6'(mirror ? tex_m : tex_raw);
      res_q.escaped        <= 1'b0;
    end else if (cmd_i.emit_esc) begin
      res_q.column_out     <= col_q;
      res_q.perp_distance  <= 16'hFFFF;
      res_q.hit_side       <= side_q;
      res_q.wall_code      <= '0;
      res_q.column_height  <= '0;
      res_q.draw_top       <= hh;
      res_q.draw_bottom    <= hh;
      res_q.texture_column <= '0;
      res_q.escaped        <= 1'b1;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hdl/rcast_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raycaster controller
// Sequences map clear, cell writes, ray setup, DDA walk and result formatting.
// ----------------------------------------------------------------------------
module rcast_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                action_i,
  input  rcast_pkg::dp_sts_t  sts_i,
  output rcast_pkg::dp_cmd_t  cmd_o,
  output logic                busy_o
);
  import rcast_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAM_GO, S_CAM_WAIT, S_RAY_MUL, S_RAY_ADD,
    S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT, S_INIT, S_START,
    S_STEP, S_CHECK, S_DIST, S_TEX, S_HGT_WAIT, S_FIN, S_ESC
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          if (action_i == ACT_CAST) begin
            cmd_o.ld_item = 1'b1;
            state_d       = S_CAM_GO;
          end else begin
            cmd_o.wr_cell = 1'b1;
          end
        end
      end
      S_CAM_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_CAM;
        state_d         = S_CAM_WAIT;
      end
      S_CAM_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.ld_cam = 1'b1;
          state_d      = S_RAY_MUL;
        end
      end
      S_RAY_MUL: begin
        cmd_o.mul_ray = 1'b1;
        state_d       = S_RAY_ADD;
      end
      S_RAY_ADD: begin
        cmd_o.add_ray = 1'b1;
        state_d       = S_DX_GO;
      end
      S_DX_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DX;
        state_d         = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.ld_dx = 1'b1;
          state_d     = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DY;
        state_d         = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.ld_dy = 1'b1;
          state_d     = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init_walk = 1'b1;
        state_d         = S_START;
      end
      // camera outside the grid escapes before any step
      S_START: state_d = sts_i.oob ? S_ESC : S_STEP;
      S_STEP: begin
        cmd_o.walk_step = 1'b1;
        state_d         = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.oob)             state_d = S_ESC;
        else if (sts_i.hit)        state_d = S_DIST;
        else if (sts_i.walk_limit) state_d = S_ESC;
        else                       state_d = S_STEP;
      end
      S_DIST: begin
        cmd_o.ld_pd = 1'b1;
        state_d     = S_TEX;
      end
      S_TEX: begin
        cmd_o.ld_frac   = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_HGT;
        state_d         = S_HGT_WAIT;
      end
      S_HGT_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.ld_lh = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.emit_hit = 1'b1;
        state_d        = S_IDLE;
      end
      S_ESC: begin
        cmd_o.emit_esc = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // a map lookup is only judged right after a step
  a_check_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> $past(state_q) == S_STEP)
    else $error("check without a preceding step");

  // divider never reports done the cycle after a start
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !sts_i.div_done)
    else $error("divider done too early");

  // quotient only arrives while a wait state holds it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_CAM_WAIT || state_q == S_DX_WAIT ||
                        state_q == S_DY_WAIT || state_q == S_HGT_WAIT))
    else $error("divider done outside a wait state");

endmodule

### hdl/dda_grid_wall_raycaster.sv
`timescale 1ns / 1ps
// A hit runs four divisions on one shared divider, an escape three; each DDA
//   step passes through a step state and then a check state.
// One cast at a time; a cell write is taken in idle and leaves busy low.
// Reset: config registers take their defaults; the map is then swept to empty,
//   one cell per cycle with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
// DDA grid wall raycaster
// Casts one screen column through the stored tile map and reports the wall hit or the escape.
// ----------------------------------------------------------------------------
module dda_grid_wall_raycaster (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rcast_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [rcast_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                         start,
  input  rcast_pkg::in_item_t          item_i,
  output logic                         busy,
  output logic                         res_valid_o,
  output rcast_pkg::out_item_t         res_o
);
  import rcast_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller
  rcast_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (item_i.action),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // datapath
  rcast_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raycaster testbench
// Drives map writes and column casts into the DDA raycaster, predicts every
// column result with an in-bench fixed-point walker and compares each whole
// result, across several camera and screen settings.
// ----------------------------------------------------------------------------

// Scoreboard: holds predicted column results in arrival order
class column_board;
  rcast_pkg::out_item_t pending[$];
  int mismatches;
  int matched;

  function void note_cast(rcast_pkg::out_item_t exp_res);
    pending = {pending, exp_res};
  endfunction

  function void check_result(rcast_pkg::out_item_t got);
    rcast_pkg::out_item_t exp_res;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
      return;
    end
    exp_res = pending.pop_front();
    if (got !== exp_res) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: column mismatch\n  exp %p\n  got %p", exp_res, got);
    end else begin
      matched++;
    end
  endfunction
endclass

module tb_top;
  import rcast_pkg::*;

  localparam int IN_W = $bits(in_item_t);

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              start = 1'b0;
  in_item_t          item_i = '0;
  logic              busy;
  logic              res_valid_o;
  out_item_t         res_o;

  dda_grid_wall_raycaster dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .start(start), .item_i(item_i), .busy(busy),
    .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]         grid_map [MAP_DEPTH];
  logic [13:0]        pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [10:0]        scr_w, scr_h;

  column_board board;
  int  idle_pct;
  int  n_casts, n_writes, n_esc;

  function automatic longint floor_q14(longint v);
    if (v >= 0) return v >>> 14;
    return -((-v + 16383) >>> 14);
  endfunction

  function automatic longint inv_step(longint r);
    longint m;
    m = (r < 0) ? -r : r;
    if (m == 0) return 64'hFFFF_FFFF;
    return (64'd1 << 30) / m;
  endfunction

  // Walk one column through the predicted map
  function automatic out_item_t cast_column(logic [9:0] col);
    out_item_t o;
    longint w, h, cam, rx, ry, dx, dy, sx, sy, fx, fy, d, fr, q;
    longint mx, my, pd, lh, top, bot, tex, code;
    int side, esc;
    w = (scr_w == 0) ? 1 : scr_w;
    h = scr_h;
    cam = (2 * longint'(col) * 16384) / w - 16384;
    rx = longint'(dir_x) + floor_q14(longint'(plane_x) * cam);
    ry = longint'(dir_y) + floor_q14(longint'(plane_y) * cam);
    mx = pos_x >> 8;
    my = pos_y >> 8;
    fx = pos_x & 8'hFF;
    fy = pos_y & 8'hFF;
    dx = inv_step(rx);
    dy = inv_step(ry);
    sx = (((rx < 0) ? fx : 256 - fx) * dx) >>> 8;
    sy = (((ry < 0) ? fy : 256 - fy) * dy) >>> 8;
    side = 0; esc = 1; code = 0;
    if (mx < MAP_SIZE && my < MAP_SIZE) begin
      for (int i = 0; i < MAX_STEPS; i++) begin
        if (sx < sy) begin
          sx += dx; mx = (rx < 0) ? mx - 1 : mx + 1; side = 0;
        end else begin
          sy += dy; my = (ry < 0) ? my - 1 : my + 1; side = 1;
        end
        if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE) break;
        code = grid_map[my * MAP_SIZE + mx];
        if (code != 0) begin
          esc = 0;
          break;
        end
      end
    end
    if (esc) begin
      pd = 16'hFFFF; code = 0; lh = 0; top = h / 2; bot = h / 2; tex = 0;
    end else begin
      d = (side ? sy - dy : sx - dx) >>> 8;
      pd = (d > 16'hFFFF) ? 16'hFFFF : d;
      if (pd == 0) lh = 16'hFFFF;
      else begin
        q = (h << 8) / pd;
        lh = (q > 16'hFFFF) ? 16'hFFFF : q;
      end
      top = (h / 2 >= lh / 2) ? h / 2 - lh / 2 : 0;
      bot = top + lh;
      if (bot > h) bot = h;
      fr = side ? (longint'(pos_x) << 14) + pd * rx : (longint'(pos_y) << 14) + pd * ry;
      fr &= (64'd1 << 22) - 1;
      tex = (fr * TEX_WIDTH) >>> 22;
      if ((!side && rx > 0) || (side && ry < 0)) tex = TEX_WIDTH - tex - 1;
    end
    o.column_out     = col;
    o.perp_distance  = pd[15:0];
    o.hit_side       = side[0];
    o.wall_code      = code[7:0];
    o.column_height  = lh[15:0];
    o.draw_top       = top[10:0];
    o.draw_bottom    = bot[10:0];
    o.texture_column = tex[5:0];
    o.escaped        = esc[0];
    if (esc) n_esc++;
    return o;
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) board.check_result(res_o);
  end

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    // config only changes with nothing in flight
    start <= 1'b0;
    while (board.pending.size() != 0 || busy) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_CAM_POS_X:   pos_x = val[13:0];
      REG_CAM_POS_Y:   pos_y = val[13:0];
      REG_VIEW_DIR_X:  dir_x = val;
      REG_VIEW_DIR_Y:  dir_y = val;
      REG_CAM_PLANE_X: plane_x = val;
      REG_CAM_PLANE_Y: plane_y = val;
      REG_SCR_WIDTH:   scr_w = val[10:0];
      REG_SCR_HEIGHT:  scr_h = val[10:0];
      default: ;
    endcase
  endtask

  // Drive one item; start stays high across back-to-back items
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if (it.action == ACT_CAST) begin
      board.note_cast(cast_column(it.column));
      n_casts++;
    end else begin
      grid_map[{it.cell_row, it.cell_col}] = it.cell_code;
      n_writes++;
    end
    @(negedge clk_i);
  endtask

  task automatic put_cell(int c, int r, int code);
    in_item_t it;
    it = '0;
    it.action = ACT_WRITE; it.cell_col = 6'(c); it.cell_row = 6'(r);
    it.cell_code = 8'(code);
    send_item(it);
  endtask

  task automatic cast(int col);
    in_item_t it;
    it = '0;
    it.action = ACT_CAST; it.column = 10'(col);
    it.cell_col = 6'($urandom); it.cell_row = 6'($urandom); it.cell_code = 8'($urandom);
    send_item(it);
  endtask

  // Wait for all results, then the block's worst-case latency
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (450) @(negedge clk_i);
  endtask

  task automatic random_item(int phase_w);
    in_item_t it;
    int r;
    r = $urandom_range(99);
    it = IN_W'($urandom);
    if (r < 35) begin
      it.action = ACT_WRITE;
      if ($urandom_range(3) == 0) it.cell_code = 0;
    end else begin
      it.action = ACT_CAST;
      it.column = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(phase_w));
    end
    send_item(it);
  endtask

  task automatic random_view();
    write_reg(REG_CAM_POS_X, 16'($urandom_range(16383)));
    write_reg(REG_CAM_POS_Y, 16'($urandom_range(16383)));
    write_reg(REG_VIEW_DIR_X, 16'($urandom));
    write_reg(REG_VIEW_DIR_Y, 16'($urandom));
    write_reg(REG_CAM_PLANE_X, 16'($urandom));
    write_reg(REG_CAM_PLANE_Y, 16'($urandom));
    write_reg(REG_SCR_WIDTH, 16'($urandom_range(2047)));
    write_reg(REG_SCR_HEIGHT, 16'($urandom_range(2047)));
  endtask

  // inner camera, kept off the border cells of the grid
  task automatic inner_view();
    write_reg(REG_CAM_POS_X, 16'($urandom_range(15872, 256)));
    write_reg(REG_CAM_POS_Y, 16'($urandom_range(15872, 256)));
    write_reg(REG_VIEW_DIR_X, 16'($urandom_range(32767) - 16384));
    write_reg(REG_VIEW_DIR_Y, 16'($urandom_range(32767) - 16384));
    write_reg(REG_CAM_PLANE_X, 16'($urandom_range(21626) - 10813));
    write_reg(REG_CAM_PLANE_Y, 16'($urandom_range(21626) - 10813));
    write_reg(REG_SCR_WIDTH, 16'($urandom_range(1024, 1)));
    write_reg(REG_SCR_HEIGHT, 16'($urandom_range(1024, 1)));
  endtask

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    board = new();
    foreach (grid_map[i]) grid_map[i] = 8'd0;
    pos_x = 0; pos_y = 0; dir_x = 16384; dir_y = 0;
    plane_x = 0; plane_y = 10813; scr_w = 640; scr_h = 480;
    idle_pct = 7;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults on an empty map escape from the corner
    cast(0); cast(1023);
    // border walls and a wall right beside the camera
    for (int k = 0; k < 64; k += 9) begin
      put_cell(k, 0, 255); put_cell(k, 63, 1);
    end
    put_cell(63, 63, 0);
    write_reg(REG_CAM_POS_X, 16'd2 << 8 | 16'd128);
    write_reg(REG_CAM_POS_Y, 16'd1 << 8);
    put_cell(3, 1, 7);
    cast(320); cast(0);
    // axis-aligned rays, zero step component
    write_reg(REG_CAM_PLANE_Y, 16'd0);
    cast(320);
    write_reg(REG_VIEW_DIR_X, 16'h8000);
    cast(5);
    write_reg(REG_VIEW_DIR_Y, 16'h7FFF);
    write_reg(REG_CAM_PLANE_X, 16'h8000);
    // zero width, column beyond width, tall screen
    write_reg(REG_SCR_WIDTH, 16'd0);
    write_reg(REG_SCR_HEIGHT, 16'd1024);
    cast(700);
    write_reg(REG_SCR_WIDTH, 16'd1);
    cast(1023);
    // camera in the far corner cell of the grid
    write_reg(REG_CAM_POS_X, 16'h3FFF);
    write_reg(REG_CAM_POS_Y, 16'h3FFF);
    cast(9);
    write_reg(REG_SCR_HEIGHT, 16'd1);
    cast(0);
    drain();

    // random phases: sender idle 7%, then 59%, then none
    for (int ph = 0; ph < 12; ph++) begin
      int fill;
      idle_pct = (ph < 4) ? 7 : (ph < 8) ? 59 : 0;
      if (ph % 4 == 3) random_view(); else inner_view();
      fill = $urandom_range(40, 10);
      for (int k = 0; k < fill; k++)
        put_cell($urandom_range(63), $urandom_range(63), $urandom_range(255, 1));
      for (int k = 0; k < 115; k++) random_item(scr_w);
      drain();
    end

    // the checker runs on the posedge; let the last result land
    @(negedge clk_i);
    $display("Ran %0d casts (%0d escaped) and %0d map writes over 13 camera settings.",
             n_casts, n_esc, n_writes);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never came", board.mismatches,
               board.pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
hdl/rcast_pkg.sv
hdl/rcast_div.sv
hdl/rcast_dp.sv
hdl/rcast_ctrl.sv
hdl/dda_grid_wall_raycaster.sv
tb/tb_top.sv
